FILE: hw/rtl/zsn_pkg.sv
package zsn_pkg;

    // Widths of the word fields.
    localparam int MAG_W = 32;
    localparam int Z_W = 32;
    localparam int IDX_W = 16;
    localparam int ROWS_W = 10;
    localparam int BLEN_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Default baseline depth.
    localparam int BASELINE_MAX_DEF = 63;

    // Shared divide / square root unit widths.
    localparam int DIV_W = 72;
    localparam int DVS_W = 32;
    localparam int REM_W = 36;
    localparam int CNT_W = 7;
    localparam int ACC_W = 70;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] ROW_LEN_RST = 16'd256;
    localparam logic [BLEN_W-1:0] BLEN_RST = 6'd32;
    localparam logic [ROWS_W-1:0] ROWS_RST = 10'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LEN = 2'd0,
        REG_BASELINE_LEN = 2'd1,
        REG_ROW_COUNT = 2'd2
    } zsn_reg_t;

    // Operations of the shared unit.
    typedef enum logic {
        OP_DIV = 1'b0,
        OP_SQRT = 1'b1
    } zsn_op_t;

    // Request from the sequencer to the shared unit.
    typedef struct packed {
        logic start;
        zsn_op_t op;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } zsn_req_t;

    // Status from the shared unit.
    typedef struct packed {
        logic busy;
        logic done;
    } zsn_sta_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_VAR_RD,
        ST_VAR_MUL,
        ST_VAR_ACC,
        ST_VDIV_GO,
        ST_VDIV_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_Z_RD,
        ST_Z_MUL,
        ST_Z_PREP,
        ST_Z_WAIT,
        ST_Z_OUT
    } zsn_state_t;

endpackage

FILE: hw/rtl/zsn_if.sv
// Input sample channel.
interface zsn_in_if;
    logic valid;
    logic ready;
    logic [zsn_pkg::MAG_W-1:0] magnitude;

    modport source (output valid, output magnitude, input ready);
    modport sink (input valid, input magnitude, output ready);
endinterface

// Result channel.
interface zsn_out_if;
    logic valid;
    logic ready;
    logic signed [zsn_pkg::Z_W-1:0] z_score;
    logic [zsn_pkg::IDX_W-1:0] sample_index;
    logic deviation_zero;
    logic row_end;
    logic block_end;
    logic last_of_run;

    modport source (output valid, output z_score, output sample_index,
                    output deviation_zero, output row_end, output block_end,
                    output last_of_run, input ready);
    modport sink (input valid, input z_score, input sample_index,
                  input deviation_zero, input row_end, input block_end,
                  input last_of_run, output ready);
endinterface

// Configuration write channel.
interface zsn_cfg_if;
    logic valid;
    logic ready;
    logic [zsn_pkg::CFG_IDX_W-1:0] index;
    logic [zsn_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/zsn_divsqrt.sv
// Shared restoring divider and digit-by-digit square root.
// Division takes one quotient bit per cycle over the full dividend; the
// square root takes one root bit (two radicand bits) per cycle.
module zsn_divsqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  zsn_pkg::zsn_req_t              req,
    output zsn_pkg::zsn_sta_t              sta,
    output logic [zsn_pkg::DIV_W-1:0]      quotient
);

    logic [zsn_pkg::DIV_W-1:0] num_reg, num_next;
    logic [zsn_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [zsn_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [zsn_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [zsn_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    zsn_pkg::zsn_op_t op_reg, op_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    logic [zsn_pkg::REM_W-1:0] rem_sh_div;
    logic [zsn_pkg::REM_W-1:0] rem_sh_sq;
    logic [zsn_pkg::REM_W-1:0] trial;
    logic [zsn_pkg::REM_W-1:0] dvs_ext;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        op_reg <= op_next;
    end

    // One step of the selected operation.
    always_comb
    begin
        dvs_ext = {{(zsn_pkg::REM_W-zsn_pkg::DVS_W){1'b0}}, dvs_reg};
        rem_sh_div = {rem_reg[zsn_pkg::REM_W-2:0], num_reg[zsn_pkg::DIV_W-1]};
        rem_sh_sq = {rem_reg[zsn_pkg::REM_W-3:0],
                     num_reg[zsn_pkg::DIV_W-1:zsn_pkg::DIV_W-2]};
        trial = {quo_reg[zsn_pkg::REM_W-3:0], 2'b01};

        num_next = num_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        op_next = op_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start && !busy_reg)
        begin
            num_next = req.dividend;
            quo_next = '0;
            rem_next = '0;
            dvs_next = req.divisor;
            op_next = req.op;
            busy_next = 1'b1;
            if (req.op == zsn_pkg::OP_SQRT)
                cnt_next = zsn_pkg::CNT_W'(zsn_pkg::DIV_W / 2 - 4);
            else
                cnt_next = zsn_pkg::CNT_W'(zsn_pkg::DIV_W);
        end
        else if (busy_reg)
        begin
            if (op_reg == zsn_pkg::OP_SQRT)
            begin
                num_next = {num_reg[zsn_pkg::DIV_W-3:0], 2'b00};
                if (rem_sh_sq >= trial)
                begin
                    rem_next = rem_sh_sq - trial;
                    quo_next = {quo_reg[zsn_pkg::DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh_sq;
                    quo_next = {quo_reg[zsn_pkg::DIV_W-2:0], 1'b0};
                end
            end
            else
            begin
                num_next = {num_reg[zsn_pkg::DIV_W-2:0], 1'b0};
                if (rem_sh_div >= dvs_ext)
                begin
                    rem_next = rem_sh_div - dvs_ext;
                    quo_next = {quo_reg[zsn_pkg::DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh_div;
                    quo_next = {quo_reg[zsn_pkg::DIV_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == zsn_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign sta.busy = busy_reg;
    assign sta.done = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/baseline_zscore_normalizer_core.sv
// Channel     Dir  Handshake      Word
// sample_in   in   valid/ready    magnitude (unsigned Q16.16)
// result_out  out  valid/ready    z_score, sample_index, flags
// cfg         in   valid/ready    index, data (always ready)
//
// One item at a time. A sample past the baseline is squared, then divided
// on the shared unit (72 steps). The sample that completes the baseline
// sums the buffer, finds mean, variance and deviation, then scores each of
// the m baseline samples; a zero deviation skips each score's divide.
// Earlier baseline samples are only buffered. Reset is asynchronous,
// active low, and needs no clearing pass. A stalled result holds the
// sequencer in its output state; the input is not ready meanwhile.
module baseline_zscore_normalizer_core #(
    parameter int BASELINE_MAX = zsn_pkg::BASELINE_MAX_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    zsn_in_if.sink       sample_in,
    zsn_out_if.source    result_out,
    zsn_cfg_if.sink      cfg
);

    localparam int AW = $clog2(BASELINE_MAX);

    // Configuration registers.
    logic [zsn_pkg::CFG_DATA_W-1:0] row_len_reg;
    logic [zsn_pkg::BLEN_W-1:0] blen_reg;
    logic [zsn_pkg::ROWS_W-1:0] rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_len_reg <= zsn_pkg::ROW_LEN_RST;
            blen_reg <= zsn_pkg::BLEN_RST;
            rows_reg <= zsn_pkg::ROWS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                zsn_pkg::REG_ROW_LEN: row_len_reg <= cfg.data;
                zsn_pkg::REG_BASELINE_LEN: blen_reg <= cfg.data[zsn_pkg::BLEN_W-1:0];
                zsn_pkg::REG_ROW_COUNT: rows_reg <= cfg.data[zsn_pkg::ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // Effective row geometry from the registers.
    logic [zsn_pkg::BLEN_W-1:0] m_eff;
    logic [zsn_pkg::IDX_W-1:0] len_eff;
    logic [zsn_pkg::ROWS_W-1:0] rc_eff;
    logic [zsn_pkg::IDX_W-1:0] pos_reg, pos_next;
    logic [zsn_pkg::ROWS_W-1:0] rowp_reg, rowp_next;
    logic end_row_now, end_block_now, in_base_now;
    logic in_acc;

    always_comb
    begin
        if (blen_reg < zsn_pkg::BLEN_W'(2))
            m_eff = zsn_pkg::BLEN_W'(2);
        else if (blen_reg > zsn_pkg::BLEN_W'(BASELINE_MAX))
            m_eff = zsn_pkg::BLEN_W'(BASELINE_MAX);
        else
            m_eff = blen_reg;
        if (row_len_reg < zsn_pkg::IDX_W'(m_eff))
            len_eff = zsn_pkg::IDX_W'(m_eff);
        else
            len_eff = row_len_reg;
        rc_eff = (rows_reg == '0) ? zsn_pkg::ROWS_W'(1) : rows_reg;
        end_row_now = ({1'b0, pos_reg} + 17'd1) >= {1'b0, len_eff};
        end_block_now = end_row_now &&
                        (({1'b0, rowp_reg} + 11'd1) >= {1'b0, rc_eff});
        in_base_now = pos_reg < zsn_pkg::IDX_W'(m_eff);
    end

    // Sequencer state and item registers.
    zsn_pkg::zsn_state_t state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [zsn_pkg::BLEN_W-1:0] m_reg;
    logic [zsn_pkg::IDX_W-1:0] ipos_reg;
    logic [zsn_pkg::MAG_W-1:0] x_reg;
    logic end_row_reg, end_block_reg, single_reg, trig_reg;
    logic [zsn_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [zsn_pkg::MAG_W-1:0] mean_reg, mean_next;
    logic [zsn_pkg::MAG_W-1:0] dev_reg, dev_next;
    logic neg_reg, neg_next;
    logic [zsn_pkg::Z_W-1:0] zres_reg, zres_next;
    logic dz_reg, dz_next;

    // Output register.
    logic ovalid_reg, ovalid_next;
    logic [zsn_pkg::Z_W-1:0] oz_reg, oz_next;
    logic [zsn_pkg::IDX_W-1:0] oidx_reg, oidx_next;
    logic odz_reg, odz_next, orend_reg, orend_next;
    logic obend_reg, obend_next, olast_reg, olast_next;

    // Baseline buffer and its registered read port.
    logic [zsn_pkg::MAG_W-1:0] buf_mem [BASELINE_MAX];
    logic [zsn_pkg::MAG_W-1:0] rd_data_reg;

    // Multiplier with a registered product.
    logic [zsn_pkg::MAG_W-1:0] mul_a;
    logic [2*zsn_pkg::MAG_W-1:0] prod_reg;

    // Shared unit.
    zsn_pkg::zsn_req_t req;
    zsn_pkg::zsn_sta_t sta;
    logic [zsn_pkg::DIV_W-1:0] quotient;

    zsn_divsqrt u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .sta      (sta),
        .quotient (quotient)
    );

    assign in_acc = sample_in.valid && sample_in.ready;
    assign sample_in.ready = (state_reg == zsn_pkg::ST_IDLE);

    // Buffer write on accepted baseline samples, read every cycle.
    always_ff @(posedge clk)
    begin
        if (in_acc && in_base_now)
            buf_mem[pos_reg[AW-1:0]] <= sample_in.magnitude;
        rd_data_reg <= buf_mem[idx_reg];
        prod_reg <= mul_a * mul_a;
    end

    // Item registers captured at accept.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            m_reg <= m_eff;
            ipos_reg <= pos_reg;
            x_reg <= sample_in.magnitude;
            end_row_reg <= end_row_now;
            end_block_reg <= end_block_now;
            single_reg <= !in_base_now;
            trig_reg <= in_base_now && (pos_reg == zsn_pkg::IDX_W'(m_eff - 1'b1));
        end
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        zres_reg <= zres_next;
        dz_reg <= dz_next;
        oz_reg <= oz_next;
        oidx_reg <= oidx_next;
        odz_reg <= odz_next;
        orend_reg <= orend_next;
        obend_reg <= obend_next;
        olast_reg <= olast_next;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zsn_pkg::ST_IDLE;
            idx_reg <= '0;
            pos_reg <= '0;
            rowp_reg <= '0;
            mean_reg <= '0;
            dev_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            pos_reg <= pos_next;
            rowp_reg <= rowp_next;
            mean_reg <= mean_next;
            dev_reg <= dev_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Sequencer.
    logic [zsn_pkg::MAG_W-1:0] dmag;
    logic [47:0] psq;
    logic [47:0] zmag;
    logic idx_last;
    logic quo_sat;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        rowp_next = rowp_reg;
        acc_next = acc_reg;
        mean_next = mean_reg;
        dev_next = dev_reg;
        neg_next = neg_reg;
        zres_next = zres_reg;
        dz_next = dz_reg;
        ovalid_next = ovalid_reg;
        oz_next = oz_reg;
        oidx_next = oidx_reg;
        odz_next = odz_reg;
        orend_next = orend_reg;
        obend_next = obend_reg;
        olast_next = olast_reg;
        req.start = 1'b0;
        req.op = zsn_pkg::OP_DIV;
        req.dividend = '0;
        req.divisor = '0;
        mul_a = '0;

        idx_last = (zsn_pkg::BLEN_W'(idx_reg) == m_reg - 1'b1);
        dmag = (rd_data_reg >= mean_reg) ? rd_data_reg - mean_reg
                                         : mean_reg - rd_data_reg;
        psq = prod_reg[63:16];
        zmag = (psq < {16'd0, mean_reg}) ? {16'd0, mean_reg} - psq
                                         : psq - {16'd0, mean_reg};
        quo_sat = |quotient[zsn_pkg::DIV_W-1:31];

        // A taken result frees the output register.
        if (result_out.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            zsn_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = zsn_pkg::ST_DISPATCH;
                    if (end_row_now)
                    begin
                        pos_next = '0;
                        rowp_next = end_block_now ? '0 : rowp_reg + 1'b1;
                    end
                    else
                        pos_next = pos_reg + 1'b1;
                end
            end
            zsn_pkg::ST_DISPATCH:
            begin
                idx_next = '0;
                acc_next = '0;
                if (single_reg)
                    state_next = zsn_pkg::ST_Z_MUL;
                else if (trig_reg)
                    state_next = zsn_pkg::ST_SUM_RD;
                else
                    state_next = zsn_pkg::ST_IDLE;
            end
            zsn_pkg::ST_SUM_RD:
                state_next = zsn_pkg::ST_SUM_ACC;
            zsn_pkg::ST_SUM_ACC:
            begin
                acc_next = acc_reg + zsn_pkg::ACC_W'(rd_data_reg);
                if (idx_last)
                begin
                    idx_next = '0;
                    state_next = zsn_pkg::ST_MEAN_GO;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = zsn_pkg::ST_SUM_RD;
                end
            end
            zsn_pkg::ST_MEAN_GO:
            begin
                req.start = 1'b1;
                req.op = zsn_pkg::OP_DIV;
                req.dividend = zsn_pkg::DIV_W'(acc_reg);
                req.divisor = zsn_pkg::DVS_W'(m_reg);
                state_next = zsn_pkg::ST_MEAN_WAIT;
            end
            zsn_pkg::ST_MEAN_WAIT:
            begin
                if (sta.done)
                begin
                    mean_next = quotient[zsn_pkg::MAG_W-1:0];
                    acc_next = '0;
                    state_next = zsn_pkg::ST_VAR_RD;
                end
            end
            zsn_pkg::ST_VAR_RD:
                state_next = zsn_pkg::ST_VAR_MUL;
            zsn_pkg::ST_VAR_MUL:
            begin
                mul_a = dmag;
                state_next = zsn_pkg::ST_VAR_ACC;
            end
            zsn_pkg::ST_VAR_ACC:
            begin
                acc_next = acc_reg + zsn_pkg::ACC_W'(prod_reg);
                if (idx_last)
                begin
                    idx_next = '0;
                    state_next = zsn_pkg::ST_VDIV_GO;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = zsn_pkg::ST_VAR_RD;
                end
            end
            zsn_pkg::ST_VDIV_GO:
            begin
                req.start = 1'b1;
                req.op = zsn_pkg::OP_DIV;
                req.dividend = zsn_pkg::DIV_W'(acc_reg);
                req.divisor = zsn_pkg::DVS_W'(m_reg - 1'b1);
                state_next = zsn_pkg::ST_VDIV_WAIT;
            end
            zsn_pkg::ST_VDIV_WAIT:
            begin
                if (sta.done)
                begin
                    // Variance saturates at the top of 64 bits.
                    if (|quotient[zsn_pkg::DIV_W-1:64])
                        acc_next = {6'd0, {64{1'b1}}};
                    else
                        acc_next = {6'd0, quotient[63:0]};
                    state_next = zsn_pkg::ST_SQRT_GO;
                end
            end
            zsn_pkg::ST_SQRT_GO:
            begin
                req.start = 1'b1;
                req.op = zsn_pkg::OP_SQRT;
                req.dividend = {acc_reg[63:0], 8'd0};
                state_next = zsn_pkg::ST_SQRT_WAIT;
            end
            zsn_pkg::ST_SQRT_WAIT:
            begin
                if (sta.done)
                begin
                    dev_next = quotient[zsn_pkg::MAG_W-1:0];
                    idx_next = '0;
                    state_next = zsn_pkg::ST_Z_RD;
                end
            end
            zsn_pkg::ST_Z_RD:
                state_next = zsn_pkg::ST_Z_MUL;
            zsn_pkg::ST_Z_MUL:
            begin
                mul_a = single_reg ? x_reg : rd_data_reg;
                state_next = zsn_pkg::ST_Z_PREP;
            end
            zsn_pkg::ST_Z_PREP:
            begin
                neg_next = psq < {16'd0, mean_reg};
                if (dev_reg == '0)
                begin
                    // Zero deviation forces a zero result.
                    zres_next = '0;
                    dz_next = 1'b1;
                    state_next = zsn_pkg::ST_Z_OUT;
                end
                else
                begin
                    dz_next = 1'b0;
                    req.start = 1'b1;
                    req.op = zsn_pkg::OP_DIV;
                    req.dividend = {8'd0, zmag, 16'd0};
                    req.divisor = dev_reg;
                    state_next = zsn_pkg::ST_Z_WAIT;
                end
            end
            zsn_pkg::ST_Z_WAIT:
            begin
                if (sta.done)
                begin
                    if (neg_reg)
                        zres_next = quo_sat ? 32'h8000_0000
                                            : 32'd0 - quotient[31:0];
                    else
                        zres_next = quo_sat ? 32'h7FFF_FFFF : quotient[31:0];
                    state_next = zsn_pkg::ST_Z_OUT;
                end
            end
            zsn_pkg::ST_Z_OUT:
            begin
                if (!ovalid_reg || result_out.ready)
                begin
                    ovalid_next = 1'b1;
                    oz_next = zres_reg;
                    odz_next = dz_reg;
                    oidx_next = single_reg ? ipos_reg : zsn_pkg::IDX_W'(idx_reg);
                    olast_next = single_reg || idx_last;
                    orend_next = (single_reg || idx_last) && end_row_reg;
                    obend_next = (single_reg || idx_last) && end_block_reg;
                    if (single_reg || idx_last)
                        state_next = zsn_pkg::ST_IDLE;
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = zsn_pkg::ST_Z_RD;
                    end
                end
            end
            default:
                state_next = zsn_pkg::ST_IDLE;
        endcase
    end

    assign result_out.valid = ovalid_reg;
    assign result_out.z_score = oz_reg;
    assign result_out.sample_index = oidx_reg;
    assign result_out.deviation_zero = odz_reg;
    assign result_out.row_end = orend_reg;
    assign result_out.block_end = obend_reg;
    assign result_out.last_of_run = olast_reg;

endmodule

FILE: hw/rtl/zsn_checker.sv
// Port-level checks on the normalizer.
module zsn_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [zsn_pkg::Z_W-1:0]       z_score,
    input logic                          deviation_zero,
    input logic                          row_end,
    input logic                          block_end,
    input logic                          last_of_run
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(z_score))
        else $error("result changed while stalled");

    // One item at a time: no input taken right after an accept.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // Row and block ends come only on the final result of an input.
    a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (row_end || block_end) |-> last_of_run && row_end)
        else $error("end flags on a non-final result");

    // A zero deviation gives a zero score.
    a_dev_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && deviation_zero |-> z_score == '0)
        else $error("nonzero score with zero deviation");

endmodule

bind baseline_zscore_normalizer_core zsn_checker u_zsn_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sample_in.valid),
    .in_ready       (sample_in.ready),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .z_score        (result_out.z_score),
    .deviation_zero (result_out.deviation_zero),
    .row_end        (result_out.row_end),
    .block_end      (result_out.block_end),
    .last_of_run    (result_out.last_of_run)
);
